### hdl/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nnzs_pkg.sv
// Shared constants and controller/datapath interface types for the zoom scaler
`timescale 1ns / 1ps
package nnzs_pkg;

  localparam int MAX_VIEW_SIDE = 256;
  localparam int ADDR_W        = 16;
  localparam int PIX_W         = 32;
  localparam int POS_W         = 13;
  localparam int SIDE_W        = 9;
  localparam int RATIO_W       = 13;
  localparam int SCREEN_W      = 14;
  localparam int DIVIDEND_W    = 17;
  localparam int QUOT_W        = 9;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_FETCH  = 2'd1;
  localparam logic [1:0] CMD_CURSOR = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] REG_ZOOM      = 3'd0;
  localparam logic [2:0] REG_VIEW_W    = 3'd1;
  localparam logic [2:0] REG_VIEW_H    = 3'd2;
  localparam logic [2:0] REG_SCREEN_W  = 3'd3;
  localparam logic [2:0] REG_SCREEN_H  = 3'd4;

  // Divide operand selects
  localparam logic [1:0] SEL_COLS = 2'd0;
  localparam logic [1:0] SEL_ROWS = 2'd1;
  localparam logic [1:0] SEL_SX   = 2'd2;
  localparam logic [1:0] SEL_SY   = 2'd3;

  typedef struct packed {
    logic       latch_in;
    logic       write_mem;
    logic       div_start;
    logic [1:0] div_sel;
    logic       calc_addr;
    logic       read_mem;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

### hdl/nearest_neighbor_zoom_scaler_core.sv
// Top level of the nearest-neighbor zoom scaler
`timescale 1ns / 1ps
// Screen magnifier core. Requests on the slave stream carry a command in tuser:
// load (stores one captured pixel at the load pointer, or at 0 on restart, no result),
// fetch (returns the next magnified pixel of the box in raster order, tlast on
// the final pixel of the box) and cursor (returns the clamped capture origin).
// Both result kinds carry the current capture size, floor(view*256/ratio) with
// a minimum of 4. One request is worked at a time, paced by a shared restoring
// divider. A cursor request runs two divides (for the capture size), a fetch
// four (capture size plus source column and row), then an address multiply
// and a registered read of the 64K-word frame store. The result register lets
// the next request be taken while a result waits; the block stalls only when a
// new result is ready and the old one is still not taken. Config writes must be
// made while idle; frame store entries must be loaded before they are fetched.
module nearest_neighbor_zoom_scaler_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // restart[0], source_pixel[32:1], cursor_x[45:33], cursor_y[58:46], zero fill
  input  logic [63:0]                   s_axis_tdata,
  // command[1:0]
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // output_pixel[31:0], origin_x[44:32], origin_y[57:45],
  // capture_cols[66:58], capture_rows[75:67], zero fill
  output logic [79:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [nnzs_pkg::SCREEN_W-1:0] cfg_data
);

  nnzs_pkg::ctrl_cmd_t  cmd;
  nnzs_pkg::dp_status_t status;

  // Sequencer: one request in flight, steps divides and store access
  nnzs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers, frame store, divider and result register
  nnzs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_kind   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

### hdl/nnzs_div.sv
// Restoring divider, one quotient bit per cycle, quotient below 512
`timescale 1ns / 1ps
module nnzs_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [nnzs_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [nnzs_pkg::RATIO_W-1:0]       divisor,
  output logic                               done,
  output logic [nnzs_pkg::QUOT_W-1:0]        quotient
);

  logic [nnzs_pkg::RATIO_W-1:0] rem;
  logic [nnzs_pkg::QUOT_W-1:0]  bits;
  logic [3:0]                   cnt;
  logic                         busy;
  logic [nnzs_pkg::RATIO_W:0]   trial;
  logic                         ge;

  // divisor >= 256, so the top 8 dividend bits start as the partial remainder
  assign trial = {rem, bits[nnzs_pkg::QUOT_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= {5'd0, dividend[nnzs_pkg::DIVIDEND_W-1:nnzs_pkg::QUOT_W]};
        bits     <= dividend[nnzs_pkg::QUOT_W-1:0];
        quotient <= '0;
        cnt      <= 4'(nnzs_pkg::QUOT_W);
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? 13'(trial - {1'b0, divisor}) : trial[nnzs_pkg::RATIO_W-1:0];
        bits     <= {bits[nnzs_pkg::QUOT_W-2:0], 1'b0};
        quotient <= {quotient[nnzs_pkg::QUOT_W-2:0], ge};
        cnt      <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/nnzs_dp.sv
// Datapath: config registers, frame store, divider, raster and result register
`timescale 1ns / 1ps
module nnzs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  nnzs_pkg::ctrl_cmd_t           cmd,
  output nnzs_pkg::dp_status_t          status,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [nnzs_pkg::SCREEN_W-1:0] cfg_data,
  input  logic [1:0]                    in_kind,
  input  logic [63:0]                   in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [79:0]                   out_data,
  output logic                          out_last
);

  logic [nnzs_pkg::RATIO_W-1:0]  zoom;
  logic [nnzs_pkg::SIDE_W-1:0]   view_w, view_h;
  logic [nnzs_pkg::SCREEN_W-1:0] scr_w, scr_h;

  logic [1:0]                    kind;
  logic                          restart;
  logic [nnzs_pkg::PIX_W-1:0]    pix_in;
  logic [nnzs_pkg::POS_W-1:0]    cx, cy;

  logic [nnzs_pkg::PIX_W-1:0]    store [2**nnzs_pkg::ADDR_W];
  logic [nnzs_pkg::ADDR_W-1:0]   load_ptr, wr_addr, rd_addr;
  logic [nnzs_pkg::PIX_W-1:0]    rd_data;

  logic [7:0]                    col, row;
  logic [nnzs_pkg::SIDE_W-1:0]   cols, rows, sx, sy;
  logic [nnzs_pkg::SIDE_W-1:0]   vw, vh;
  logic [nnzs_pkg::RATIO_W-1:0]  ratio;
  logic [nnzs_pkg::DIVIDEND_W-1:0] dividend;
  logic [nnzs_pkg::QUOT_W-1:0]   q;
  logic                          div_done;
  logic [nnzs_pkg::SIDE_W-1:0]   col_next, row_next;
  logic                          last;
  logic [nnzs_pkg::POS_W-1:0]    ox, oy;

  always_comb begin
    ratio = (zoom < 13'd256) ? 13'd256 : zoom;
    vw = (view_w == '0) ? 9'd1 : (view_w > 9'(nnzs_pkg::MAX_VIEW_SIDE)) ?
         9'(nnzs_pkg::MAX_VIEW_SIDE) : view_w;
    vh = (view_h == '0) ? 9'd1 : (view_h > 9'(nnzs_pkg::MAX_VIEW_SIDE)) ?
         9'(nnzs_pkg::MAX_VIEW_SIDE) : view_h;
    case (cmd.div_sel)
      nnzs_pkg::SEL_COLS: dividend = {vw, 8'd0};
      nnzs_pkg::SEL_ROWS: dividend = {vh, 8'd0};
      nnzs_pkg::SEL_SX:   dividend = {1'b0, col, 8'd0};
      nnzs_pkg::SEL_SY:   dividend = {1'b0, row, 8'd0};
      default:            dividend = '0;
    endcase
  end

  nnzs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (ratio),
    .done     (div_done),
    .quotient (q)
  );

  assign status.div_done = div_done;
  assign status.out_busy = out_valid && !out_ready;

  // Origin: center on the cursor, then clamp into the screen
  function automatic logic [12:0] clamp_org(input logic [12:0] c, input logic [8:0] cap,
                                            input logic [13:0] scr);
    logic signed [15:0] o;
    o = $signed({3'd0, c}) - $signed({8'd0, cap[8:1]});
    if (o < 0) o = '0;
    if (o + $signed({7'd0, cap}) > $signed({2'd0, scr}))
      o = $signed({2'd0, scr}) - $signed({7'd0, cap});
    if (o < 0) o = '0;
    return o[12:0];
  endfunction

  assign ox       = clamp_org(cx, cols, scr_w);
  assign oy       = clamp_org(cy, rows, scr_h);
  assign last     = ({1'b0, col} == vw - 9'd1) && ({1'b0, row} == vh - 9'd1);
  assign col_next = {1'b0, col} + 9'd1;
  assign row_next = {1'b0, row} + 9'd1;
  assign wr_addr  = restart ? '0 : load_ptr;

  always_ff @(posedge clk) begin
    if (cmd.write_mem) store[wr_addr] <= pix_in;
    if (cmd.read_mem)  rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind    <= in_kind;
      restart <= in_data[0];
      pix_in  <= in_data[32:1];
      cx      <= in_data[45:33];
      cy      <= in_data[58:46];
    end
    if (div_done) begin
      case (cmd.div_sel)
        nnzs_pkg::SEL_COLS: cols <= (q < 9'd4) ? 9'd4 : q;
        nnzs_pkg::SEL_ROWS: rows <= (q < 9'd4) ? 9'd4 : q;
        nnzs_pkg::SEL_SX:   sx   <= (q >= cols) ? cols - 9'd1 : q;
        nnzs_pkg::SEL_SY:   sy   <= (q >= rows) ? rows - 9'd1 : q;
        default: ;
      endcase
    end
    if (cmd.calc_addr) rd_addr <= ({7'd0, sy} * {7'd0, cols}) + {7'd0, sx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom      <= 13'd512;
      view_w    <= 9'd256;
      view_h    <= 9'd256;
      scr_w     <= 14'd1920;
      scr_h     <= 14'd1080;
      load_ptr  <= '0;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          nnzs_pkg::REG_ZOOM:     zoom   <= cfg_data[12:0];
          nnzs_pkg::REG_VIEW_W:   view_w <= cfg_data[8:0];
          nnzs_pkg::REG_VIEW_H:   view_h <= cfg_data[8:0];
          nnzs_pkg::REG_SCREEN_W: scr_w  <= cfg_data;
          nnzs_pkg::REG_SCREEN_H: scr_h  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.write_mem) load_ptr <= wr_addr + 16'd1;
      if (cmd.latch_in && in_kind == nnzs_pkg::CMD_FETCH && in_data[0]) begin
        col <= '0;
        row <= '0;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (kind == nnzs_pkg::CMD_FETCH) begin
          if (col_next >= vw) begin
            col <= '0;
            row <= (row_next >= vh) ? '0 : row_next[7:0];
          end else begin
            col <= col_next[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (kind == nnzs_pkg::CMD_FETCH) begin
        out_data <= {4'd0, rows, cols, 13'd0, 13'd0, rd_data};
        out_last <= last;
      end else begin
        out_data <= {4'd0, rows, cols, oy, ox, 32'd0};
        out_last <= 1'b0;
      end
    end
  end

endmodule

### hdl/nnzs_ctrl.sv
// Controller state machine sequencing divides, store access and result load
`timescale 1ns / 1ps
module nnzs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  output logic                 in_ready,
  input  nnzs_pkg::dp_status_t status,
  output nnzs_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_DSTART, S_DWAIT, S_ADDR, S_READ, S_EMIT
  } state_t;

  state_t     state;
  logic [1:0] kind;
  logic [1:0] sel;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = sel;
    cmd.latch_in  = accept;
    cmd.write_mem = (state == S_WRITE);
    cmd.div_start = (state == S_DSTART);
    cmd.calc_addr = (state == S_ADDR);
    cmd.read_mem  = (state == S_READ);
    cmd.load_out  = (state == S_EMIT) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= nnzs_pkg::CMD_LOAD;
      sel   <= nnzs_pkg::SEL_COLS;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind <= in_kind;
            sel  <= nnzs_pkg::SEL_COLS;
            case (in_kind)
              nnzs_pkg::CMD_LOAD:   state <= S_WRITE;
              nnzs_pkg::CMD_FETCH,
              nnzs_pkg::CMD_CURSOR: state <= S_DSTART;
              default:              state <= S_IDLE;
            endcase
          end
        end
        S_WRITE:  state <= S_IDLE;
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (status.div_done) begin
            if (sel == nnzs_pkg::SEL_SY) begin
              state <= S_ADDR;
            end else if (sel == nnzs_pkg::SEL_ROWS && kind == nnzs_pkg::CMD_CURSOR) begin
              state <= S_EMIT;
            end else begin
              sel   <= sel + 2'd1;
              state <= S_DSTART;
            end
          end
        end
        S_ADDR: state <= S_READ;
        S_READ: state <= S_EMIT;
        S_EMIT: begin
          if (!status.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/nnzs_checker.sv
// Port-level checker for the zoom scaler, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nnzs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `ASSERT_NEXT(a_rst_clears_out, rst, !m_axis_tvalid, "result valid after reset")
  `ASSERT_IMPL(a_out_hold, $past(m_axis_tvalid && !m_axis_tready) && !$past(rst), m_axis_tvalid, "result dropped")
  `ASSERT_IMPL(a_last_no_origin, m_axis_tvalid && m_axis_tlast, m_axis_tdata[57:32] == 26'd0, "origin on pixel")
  `ASSERT_IMPL(a_cap_min, m_axis_tvalid, m_axis_tdata[66:58] >= 9'd4 && m_axis_tdata[75:67] >= 9'd4, "capture size below 4")
  `ASSERT_IMPL(a_one_in_flight,
    $past(s_axis_tvalid && s_axis_tready && s_axis_tuser != nnzs_pkg::CMD_UNUSED) && !$past(rst),
    !s_axis_tready, "second request taken")

endmodule

bind nearest_neighbor_zoom_scaler_core nnzs_checker u_nnzs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/zoom_scaler_checker.sv
// Result checker for the zoom scaler: predicts every result and compares it
`timescale 1ns / 1ps
module zoom_scaler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [31:0] pixel;
    logic        last;
    logic [12:0] ox;
    logic [12:0] oy;
    logic [8:0]  cols;
    logic [8:0]  rows;
  } zoom_result_t;

  zoom_result_t expected_results[$];

  logic [12:0] ratio;
  logic [8:0]  view_w, view_h;
  logic [13:0] scr_w, scr_h;
  logic [31:0] frame_mem [65536];
  logic [15:0] load_ptr;
  int          col_pos, row_pos;

  initial begin
    foreach (frame_mem[i]) frame_mem[i] = '0;
  end

  assign pending = expected_results.size();

  function automatic int zoom_of();
    return (ratio < 256) ? 256 : int'(ratio);
  endfunction

  function automatic int view_of(logic [8:0] v);
    if (v == 0) return 1;
    if (v > nnzs_pkg::MAX_VIEW_SIDE) return nnzs_pkg::MAX_VIEW_SIDE;
    return int'(v);
  endfunction

  function automatic int side_of(logic [8:0] v);
    int c;
    c = view_of(v) * 256 / zoom_of();
    return (c < 4) ? 4 : c;
  endfunction

  function automatic int src_of(int d, int cap);
    int s;
    s = d * 256 / zoom_of();
    return (s >= cap) ? cap - 1 : s;
  endfunction

  function automatic int origin_of(int cursor, int cap, int screen);
    int o;
    o = cursor - cap / 2;
    if (o < 0) o = 0;
    if (o + cap > screen) o = screen - cap;
    if (o < 0) o = 0;
    return o;
  endfunction

  always @(posedge clk) begin
    zoom_result_t r, got;
    int cols, rows, vw, vh, sx, sy;
    logic restart;
    if (rst) begin
      ratio    <= 13'd512;
      view_w   <= 9'd256;
      view_h   <= 9'd256;
      scr_w    <= 14'd1920;
      scr_h    <= 14'd1080;
      load_ptr <= '0;
      col_pos  <= 0;
      row_pos  <= 0;
      errors   = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          nnzs_pkg::REG_ZOOM:     ratio  <= cfg_data[12:0];
          nnzs_pkg::REG_VIEW_W:   view_w <= cfg_data[8:0];
          nnzs_pkg::REG_VIEW_H:   view_h <= cfg_data[8:0];
          nnzs_pkg::REG_SCREEN_W: scr_w  <= cfg_data;
          nnzs_pkg::REG_SCREEN_H: scr_h  <= cfg_data;
          default: ;
        endcase
      end
      // requests: blocking copies of the raster state so results stay in step
      if (s_axis_tvalid && s_axis_tready) begin
        restart = s_axis_tdata[0];
        cols = side_of(view_w);
        rows = side_of(view_h);
        r = '{pixel: '0, last: 1'b0, ox: '0, oy: '0, cols: cols[8:0], rows: rows[8:0]};
        case (s_axis_tuser)
          nnzs_pkg::CMD_LOAD: begin
            if (restart) begin
              frame_mem[0] = s_axis_tdata[32:1];
              load_ptr <= 16'd1;
            end else begin
              frame_mem[load_ptr] = s_axis_tdata[32:1];
              load_ptr <= load_ptr + 16'd1;
            end
          end
          nnzs_pkg::CMD_FETCH: begin
            vw = view_of(view_w);
            vh = view_of(view_h);
            if (restart) begin
              col_pos = 0;
              row_pos = 0;
            end
            sx = src_of(col_pos, cols);
            sy = src_of(row_pos, rows);
            r.pixel = frame_mem[sy * cols + sx];
            r.last  = (col_pos == vw - 1) && (row_pos == vh - 1);
            // positions past a shrunken box wrap like normal ones
            col_pos = col_pos + 1;
            if (col_pos >= vw) begin
              col_pos = 0;
              row_pos = row_pos + 1;
              if (row_pos >= vh) row_pos = 0;
            end
            expected_results.push_back(r);
          end
          nnzs_pkg::CMD_CURSOR: begin
            sx = origin_of(int'(s_axis_tdata[45:33]), cols, int'(scr_w));
            sy = origin_of(int'(s_axis_tdata[58:46]), rows, int'(scr_h));
            r.ox = sx[12:0];
            r.oy = sy[12:0];
            expected_results.push_back(r);
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result, tdata %h", m_axis_tdata);
          errors++;
        end else begin
          r = expected_results.pop_front();
          got.pixel = m_axis_tdata[31:0];
          got.last  = m_axis_tlast;
          got.ox    = m_axis_tdata[44:32];
          got.oy    = m_axis_tdata[57:45];
          got.cols  = m_axis_tdata[66:58];
          got.rows  = m_axis_tdata[75:67];
          if (got.pixel !== r.pixel) begin
            $error("output_pixel exp %h got %h", r.pixel, got.pixel); errors++;
          end
          if (got.last !== r.last) begin
            $error("last_pixel exp %0d got %0d", r.last, got.last); errors++;
          end
          if (got.ox !== r.ox) begin
            $error("origin_x exp %0d got %0d", r.ox, got.ox); errors++;
          end
          if (got.oy !== r.oy) begin
            $error("origin_y exp %0d got %0d", r.oy, got.oy); errors++;
          end
          if (got.cols !== r.cols) begin
            $error("capture_cols exp %0d got %0d", r.cols, got.cols); errors++;
          end
          if (got.rows !== r.rows) begin
            $error("capture_rows exp %0d got %0d", r.rows, got.rows); errors++;
          end
        end
      end
    end
  end
endmodule

### tb/nearest_neighbor_zoom_scaler_core_test.sv
// Stimulus and verdict for the nearest-neighbor zoom scaler core
`timescale 1ns / 1ps
module nearest_neighbor_zoom_scaler_core_test;

  localparam int IDLE_LIMIT = 5000;  // cycles with no handshake at all
  localparam int DRAIN_WAIT = 120;   // covers a load still in flight

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [13:0] cfg_data;
  int          errors, pending;

  bit gaps_on;    // per-phase: idle cycles drawn on both sides
  bit hold_req;   // asks the receiver for one long stall

  nearest_neighbor_zoom_scaler_core i_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  zoom_scaler_checker i_checker (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: any stretch without a handshake this long means a hang
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we || rst)
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls per result, plus one long hold on demand
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // capture side length, used only to size the frame loads
  function automatic int side_for(int view, int ratio);
    int v, z, c;
    v = (view == 0) ? 1 :
        (view > nnzs_pkg::MAX_VIEW_SIDE ? nnzs_pkg::MAX_VIEW_SIDE : view);
    z = (ratio < 256) ? 256 : ratio;
    c = v * 256 / z;
    return (c < 4) ? 4 : c;
  endfunction

  task automatic send_request(logic [1:0] cmd, logic restart, logic [31:0] pix,
                              logic [12:0] cx, logic [12:0] cy);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'd0, cy, cx, pix, restart};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // all writes back to back, only while the block is idle
  task automatic write_regs(int ratio, int vw, int vh, int sw, int sh);
    int vals[5];
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    vals = '{ratio, vw, vh, sw, sh};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i][13:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // fill every entry the fetches of this setting can touch
  task automatic load_frame(int count);
    for (int i = 0; i < count; i++)
      send_request(nnzs_pkg::CMD_LOAD, i == 0, $urandom, 13'($urandom), 13'($urandom));
  endtask

  // fetches only once the frame of the current setting is loaded
  task automatic random_traffic(int count, bit fetch_on);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 && fetch_on)
        send_request(nnzs_pkg::CMD_FETCH, $urandom_range(0, 7) == 0, $urandom,
                     13'($urandom), 13'($urandom));
      else if (pick < 80)
        send_request(nnzs_pkg::CMD_CURSOR, 1'($urandom), $urandom,
                     13'($urandom), 13'($urandom));
      else if (pick < 95)
        send_request(nnzs_pkg::CMD_LOAD, $urandom_range(0, 5) == 0, $urandom,
                     13'($urandom), 13'($urandom));
      else
        send_request(nnzs_pkg::CMD_UNUSED, 1'($urandom), $urandom,
                     13'($urandom), 13'($urandom));
    end
  endtask

  initial begin
    int cfgs[7][6];
    int cols, rows, ratio;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = nnzs_pkg::CMD_LOAD;
    cfg_we        = 1'b0;
    cfg_index     = nnzs_pkg::REG_ZOOM;
    cfg_data      = '0;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    // ratio, view w, view h, screen w, screen h, gaps
    cfgs = '{'{512, 256, 256, 1920, 1080, 1},   // reset values, nothing written, no fetches
             '{4096, 128, 128, 8192, 8192, 1},
             '{0, 8, 6, 4, 4, 1},               // ratio below one, screen smaller than window
             '{4000, 0, 511, 100, 50, 1},       // view of zero and above the maximum
             '{8191, 200, 100, 16383, 16383, 1},
             '{256, 10, 8, 1920, 1080, 0},      // no idle gaps
             '{2500, 37, 255, 8192, 4, 1}};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) write_regs(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4]);
      gaps_on = (cfgs[p][5] != 0);
      ratio = cfgs[p][0] & 16'h1fff;
      cols = side_for(cfgs[p][1] & 16'h1ff, ratio);
      rows = side_for(cfgs[p][2] & 16'h1ff, ratio);
      if (p > 0) load_frame(cols * rows);
      if (p == 1) begin
        // directed corners: cursor extremes, pixel extremes, unused command
        send_request(nnzs_pkg::CMD_CURSOR, 1'b0, '0, 13'd0, 13'd0);
        send_request(nnzs_pkg::CMD_CURSOR, 1'b1, '1, 13'h1fff, 13'h1fff);
        send_request(nnzs_pkg::CMD_CURSOR, 1'b0, '0, 13'd8, 13'd8190);
        send_request(nnzs_pkg::CMD_LOAD, 1'b1, 32'h0, '0, '0);
        send_request(nnzs_pkg::CMD_LOAD, 1'b0, 32'hffff_ffff, '1, '1);
        send_request(nnzs_pkg::CMD_FETCH, 1'b1, '0, '0, '0);
        send_request(nnzs_pkg::CMD_FETCH, 1'b0, '1, '1, '1);
        send_request(nnzs_pkg::CMD_UNUSED, 1'b1, '1, '1, '1);
        for (int i = 0; i < 16; i++) send_request(nnzs_pkg::CMD_FETCH, 1'b0, '0, '0, '0);
        hold_req = 1'b1;  // receiver stalls long while requests keep coming
        for (int i = 0; i < 30; i++)
          send_request(nnzs_pkg::CMD_FETCH, 1'b0, $urandom, '0, '0);
      end
      random_traffic(100, p > 0);
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
